// ===== hw/rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared geometry, codes and types for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int unsigned COLUMNS          = 80;
	localparam int unsigned ROWS             = 25;
	localparam int unsigned AUTO_SCROLL_ROWS = 10;

	localparam int unsigned CELLS      = COLUMNS * ROWS;
	localparam int unsigned AW         = $clog2(CELLS);
	localparam int unsigned CW         = $clog2(CELLS + 1);
	localparam int unsigned NW         = $clog2(CELLS + COLUMNS + 1);
	localparam int unsigned AUTO_ROWS  = (AUTO_SCROLL_ROWS > ROWS) ? ROWS : AUTO_SCROLL_ROWS;
	localparam int unsigned AUTO_SHIFT = AUTO_ROWS * COLUMNS;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'h07;
	localparam logic [7:0] NEWLINE    = 8'h0A;
	localparam logic [7:0] PRINT_LO   = 8'h20;
	localparam logic [7:0] PRINT_HI   = 8'h7F;

	typedef logic [2:0] mode_t;
	localparam mode_t MODE_PUT    = 3'd0;
	localparam mode_t MODE_BKSP   = 3'd1;
	localparam mode_t MODE_SETCUR = 3'd2;
	localparam mode_t MODE_CLEAR  = 3'd3;
	localparam mode_t MODE_SCROLL = 3'd4;
	localparam mode_t MODE_READ   = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEWLINE,
		ST_PUT,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_FILL,
		ST_READ
	} state_t;

	typedef enum logic [1:0] {
		FILL_INIT,
		FILL_CLEAR,
		FILL_SCROLL,
		FILL_AUTO
	} fill_kind_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [15:0]   wdata;
		logic [AW-1:0] raddr;
	} ram_req_t;

endpackage

// ===== hw/rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 text screen of character/attribute cells with a cursor.
//
// A command is transferred on a rising edge with start high and busy low;
// mode selects put char, backspace, set cursor, clear, scroll or read cell.
// Each command yields one result, shown for exactly one cycle with done high
// (cursor_pos, ok, cell_char, cell_attr); the receiver cannot stall it.
// Backspace, set cursor, ignored bytes and rejects finish at the transfer
// edge; a printable byte or a read passes its put or read state. Newline
// steps one row per cycle until it passes the cursor; clear blanks every
// cell; scroll copies each moved cell with a read and a write, then blanks
// the freed rows. A printable byte on a full screen adds an auto-scroll
// pass first. busy is high while the sequencer is out of idle and is low
// again in the done cycle, so a command that finishes at the transfer
// edge never raises it; the next command may be transferred in the done
// cycle. After reset busy is high while the store is blanked to 0x20
// with attribute 0x07; the cursor resets to 0 and the colour register to
// 0x07. text_colour is written when text_colour_we is high; the user must
// write it only while no command is in flight, which is not enforced.
// ----------------------------------------------------------------------------
module text_console_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [7:0]  char_code,
	input  logic [10:0] position,
	input  logic [4:0]  line_count,
	input  logic        text_colour_we,
	input  logic [7:0]  text_colour,
	output logic        done,
	output logic [10:0] cursor_pos,
	output logic        ok,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr
);
	import tcw_pkg::*;

	ram_req_t    ram_req;
	logic [15:0] ram_rdata;

	tcw_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.char_code      (char_code),
		.position       (position),
		.line_count     (line_count),
		.text_colour_we (text_colour_we),
		.text_colour    (text_colour),
		.done           (done),
		.cursor_pos     (cursor_pos),
		.ok             (ok),
		.cell_char      (cell_char),
		.cell_attr      (cell_attr),
		.ram_req        (ram_req),
		.ram_rdata      (ram_rdata)
	);

	tcw_screen_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

endmodule

// ===== hw/rtl/tcw_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_screen_ram (
	input  logic              clk,
	input  tcw_pkg::ram_req_t req,
	output logic [15:0]       rdata
);
	import tcw_pkg::*;

	logic [15:0] mem [CELLS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: cursor, newline row stepping, colour register, and the
// address walker that drives clear, scroll and cell transfers through the screen store.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        mode,
	input  logic [7:0]        char_code,
	input  logic [10:0]       position,
	input  logic [4:0]        line_count,
	input  logic              text_colour_we,
	input  logic [7:0]        text_colour,
	output logic              done,
	output logic [10:0]       cursor_pos,
	output logic              ok,
	output logic [7:0]        cell_char,
	output logic [7:0]        cell_attr,
	output tcw_pkg::ram_req_t ram_req,
	input  logic [15:0]       ram_rdata
);
	import tcw_pkg::*;

	state_t        state_q, state_d;
	fill_kind_t    kind_q, kind_d;
	logic [CW-1:0] cursor_q, cursor_d;
	logic [7:0]    colour_q;
	logic [AW-1:0] addr_q, addr_d;
	logic [CW-1:0] shift_q, shift_d;
	logic [NW-1:0] base_q, base_d;
	logic [7:0]    char_q, char_d;
	logic          done_q, done_d;
	logic          ok_q, ok_d;
	logic [7:0]    cell_char_q, cell_char_d;
	logic [7:0]    cell_attr_q, cell_attr_d;

	logic [NW-1:0] nl_next;
	logic [CW:0]   src;
	logic [7:0]    fill_attr;
	logic [CW-1:0] cursor_scrolled;

	assign nl_next         = base_q + NW'(COLUMNS);
	assign src             = (CW+1)'(addr_q) + (CW+1)'(shift_q);
	assign fill_attr       = (kind_q == FILL_INIT) ? RESET_ATTR : colour_q;
	assign cursor_scrolled = (cursor_q > shift_q) ? (cursor_q - shift_q) : '0;

	always_comb begin
		state_d       = state_q;
		kind_d        = kind_q;
		cursor_d      = cursor_q;
		addr_d        = addr_q;
		shift_d       = shift_q;
		base_d        = base_q;
		char_d        = char_q;
		done_d        = 1'b0;
		ok_d          = ok_q;
		cell_char_d   = cell_char_q;
		cell_attr_d   = cell_attr_q;
		ram_req.we    = 1'b0;
		ram_req.waddr = addr_q;
		ram_req.wdata = {fill_attr, BLANK_CHAR};
		ram_req.raddr = addr_q;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cell_char_d = '0;
					cell_attr_d = '0;
					ok_d        = 1'b1;
					case (mode)
						MODE_PUT: begin
							if (char_code == NEWLINE) begin
								base_d  = '0;
								state_d = ST_NEWLINE;
							end else if (char_code >= PRINT_LO && char_code <= PRINT_HI) begin
								char_d = char_code;
								if (32'(cursor_q) >= CELLS) begin
									shift_d = CW'(AUTO_SHIFT);
									addr_d  = '0;
									kind_d  = FILL_AUTO;
									state_d = ST_COPY_RD;
								end else begin
									state_d = ST_PUT;
								end
							end else begin
								done_d = 1'b1;
							end
						end
						MODE_BKSP: begin
							if (cursor_q != '0) begin
								cursor_d      = cursor_q - 1'b1;
								ram_req.we    = 1'b1;
								ram_req.waddr = AW'(cursor_q - 1'b1);
								ram_req.wdata = {RESET_ATTR, BLANK_CHAR};
							end
							done_d = 1'b1;
						end
						MODE_SETCUR: begin
							if (32'(position) < CELLS) begin
								cursor_d = CW'(position);
							end else begin
								ok_d = 1'b0;
							end
							done_d = 1'b1;
						end
						MODE_CLEAR: begin
							addr_d  = '0;
							kind_d  = FILL_CLEAR;
							state_d = ST_FILL;
						end
						MODE_SCROLL: begin
							if (32'(line_count) > ROWS) begin
								ok_d   = 1'b0;
								done_d = 1'b1;
							end else if (line_count == '0) begin
								done_d = 1'b1;
							end else begin
								shift_d = CW'(32'(line_count) * COLUMNS);
								addr_d  = '0;
								kind_d  = FILL_SCROLL;
								state_d = ST_COPY_RD;
							end
						end
						MODE_READ: begin
							if (32'(position) < CELLS) begin
								ram_req.raddr = AW'(position);
								state_d       = ST_READ;
							end else begin
								ok_d   = 1'b0;
								done_d = 1'b1;
							end
						end
						default: begin
							ok_d   = 1'b0;
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_NEWLINE: begin
				if (NW'(cursor_q) < nl_next) begin
					cursor_d = (nl_next > NW'(CELLS)) ? CW'(CELLS) : CW'(nl_next);
					done_d   = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					base_d = nl_next;
				end
			end
			ST_PUT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = AW'(cursor_q);
				ram_req.wdata = {colour_q, char_q};
				cursor_d      = cursor_q + 1'b1;
				done_d        = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_COPY_RD: begin
				if (32'(src) < CELLS) begin
					ram_req.raddr = AW'(src);
					state_d       = ST_COPY_WR;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_COPY_WR: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = ram_rdata;
				addr_d        = addr_q + 1'b1;
				state_d       = ST_COPY_RD;
			end
			ST_FILL: begin
				ram_req.we = 1'b1;
				if (32'(addr_q) == CELLS - 1) begin
					case (kind_q)
						FILL_INIT: begin
							state_d = ST_IDLE;
						end
						FILL_CLEAR: begin
							done_d  = 1'b1;
							state_d = ST_IDLE;
						end
						FILL_SCROLL: begin
							cursor_d = cursor_scrolled;
							done_d   = 1'b1;
							state_d  = ST_IDLE;
						end
						FILL_AUTO: begin
							cursor_d = cursor_scrolled;
							state_d  = ST_PUT;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end else begin
					addr_d = addr_q + 1'b1;
				end
			end
			ST_READ: begin
				cell_char_d = ram_rdata[7:0];
				cell_attr_d = ram_rdata[15:8];
				done_d      = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// reset starts a blanking pass over the whole store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_FILL;
			kind_q   <= FILL_INIT;
			cursor_q <= '0;
			colour_q <= RESET_ATTR;
			addr_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			kind_q   <= kind_d;
			cursor_q <= cursor_d;
			addr_q   <= addr_d;
			done_q   <= done_d;
			if (text_colour_we) begin
				colour_q <= text_colour;
			end
		end
	end

	always_ff @(posedge clk) begin
		shift_q     <= shift_d;
		base_q      <= base_d;
		char_q      <= char_d;
		ok_q        <= ok_d;
		cell_char_q <= cell_char_d;
		cell_attr_q <= cell_attr_d;
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign cursor_pos = 11'(cursor_q);
	assign ok         = ok_q;
	assign cell_char  = cell_char_q;
	assign cell_attr  = cell_attr_q;

endmodule

// ===== hw/rtl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [10:0] cursor_pos,
	input logic        ok,
	input logic [7:0]  cell_char,
	input logic [7:0]  cell_attr
);
	import tcw_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start) || $past(busy)))
		else $error("result without a command transfer");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (cell_char == 8'h00 && cell_attr == 8'h00))
		else $error("rejected command returned cell data");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(cursor_pos) <= CELLS))
		else $error("cursor beyond screen");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.cursor_pos (cursor_pos),
	.ok         (ok),
	.cell_char  (cell_char),
	.cell_attr  (cell_attr)
);

// ===== dv/tb_text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the 80x25 text console writer. A directed table
// covers rejects, ignored bytes, newline saturation, auto-scroll, scroll
// extremes and clear; random commands follow in phases with different sender
// idling and colour settings. Typed rows are checked against the table, all
// others against a cycle-free bench model of the screen store and cursor.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
	import tcw_pkg::*;

	localparam mode_t MODE_BAD6 = 3'd6;
	localparam mode_t MODE_BAD7 = 3'd7;

	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned PHASE_ITEMS = 425;
	localparam int unsigned NDIR        = 28;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  ch;
		logic [10:0] pos;
		logic [4:0]  lines;
	} cmd_t;

	typedef struct packed {
		logic [10:0] cursor;
		logic        ok;
		logic [7:0]  ch;
		logic [7:0]  attr;
	} result_t;

	typedef struct packed {
		cmd_t    cmd;
		logic    typed;
		result_t res;
	} stim_row_t;

	localparam result_t NO_RES = '0;

	// typed rows carry a result that can be read off directly
	localparam stim_row_t DIRECTED [NDIR] = '{
		'{'{MODE_READ,   8'h00, 11'd0,    5'd0},  1'b1, '{11'd0,    1'b1, 8'h20, 8'h07}},
		'{'{MODE_READ,   8'h00, 11'd1999, 5'd0},  1'b1, '{11'd0,    1'b1, 8'h20, 8'h07}},
		'{'{MODE_READ,   8'h00, 11'd2047, 5'd0},  1'b1, '{11'd0,    1'b0, 8'h00, 8'h00}},
		'{'{MODE_SETCUR, 8'h00, 11'd2000, 5'd0},  1'b1, '{11'd0,    1'b0, 8'h00, 8'h00}},
		'{'{MODE_SCROLL, 8'h00, 11'd0,    5'd26}, 1'b1, '{11'd0,    1'b0, 8'h00, 8'h00}},
		'{'{MODE_SCROLL, 8'h00, 11'd0,    5'd31}, 1'b1, '{11'd0,    1'b0, 8'h00, 8'h00}},
		'{'{MODE_BAD6,   8'h00, 11'd0,    5'd0},  1'b1, '{11'd0,    1'b0, 8'h00, 8'h00}},
		'{'{MODE_BAD7,   8'hFF, 11'h7FF,  5'h1F}, 1'b1, '{11'd0,    1'b0, 8'h00, 8'h00}},
		'{'{MODE_BKSP,   8'h00, 11'd0,    5'd0},  1'b1, '{11'd0,    1'b1, 8'h00, 8'h00}},
		'{'{MODE_PUT,    8'h41, 11'd0,    5'd0},  1'b1, '{11'd1,    1'b1, 8'h00, 8'h00}},
		'{'{MODE_PUT,    8'h00, 11'd0,    5'd0},  1'b1, '{11'd1,    1'b1, 8'h00, 8'h00}},
		'{'{MODE_PUT,    8'hFF, 11'd0,    5'd0},  1'b1, '{11'd1,    1'b1, 8'h00, 8'h00}},
		'{'{MODE_PUT,    8'h1F, 11'd0,    5'd0},  1'b1, '{11'd1,    1'b1, 8'h00, 8'h00}},
		'{'{MODE_PUT,    8'h20, 11'd0,    5'd0},  1'b1, '{11'd2,    1'b1, 8'h00, 8'h00}},
		'{'{MODE_PUT,    8'h7F, 11'd0,    5'd0},  1'b1, '{11'd3,    1'b1, 8'h00, 8'h00}},
		'{'{MODE_READ,   8'h00, 11'd0,    5'd0},  1'b1, '{11'd3,    1'b1, 8'h41, 8'h07}},
		'{'{MODE_BKSP,   8'h00, 11'd0,    5'd0},  1'b1, '{11'd2,    1'b1, 8'h00, 8'h00}},
		'{'{MODE_READ,   8'h00, 11'd2,    5'd0},  1'b0, NO_RES},
		'{'{MODE_PUT,    8'h0A, 11'd0,    5'd0},  1'b1, '{11'd80,   1'b1, 8'h00, 8'h00}},
		'{'{MODE_SETCUR, 8'h00, 11'd1999, 5'd0},  1'b1, '{11'd1999, 1'b1, 8'h00, 8'h00}},
		'{'{MODE_PUT,    8'h5A, 11'd0,    5'd0},  1'b1, '{11'd2000, 1'b1, 8'h00, 8'h00}},
		'{'{MODE_PUT,    8'h0A, 11'd0,    5'd0},  1'b1, '{11'd2000, 1'b1, 8'h00, 8'h00}},
		'{'{MODE_PUT,    8'h42, 11'd0,    5'd0},  1'b0, NO_RES},
		'{'{MODE_READ,   8'h00, 11'd1199, 5'd0},  1'b0, NO_RES},
		'{'{MODE_SCROLL, 8'h00, 11'd0,    5'd0},  1'b0, NO_RES},
		'{'{MODE_SCROLL, 8'h00, 11'd0,    5'd1},  1'b0, NO_RES},
		'{'{MODE_SCROLL, 8'h00, 11'd0,    5'd25}, 1'b0, NO_RES},
		'{'{MODE_CLEAR,  8'h00, 11'd0,    5'd0},  1'b0, NO_RES}
	};

	localparam int unsigned PHASE_IDLE [4] = '{0, 54, 0, 27};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  mode;
	logic [7:0]  char_code;
	logic [10:0] position;
	logic [4:0]  line_count;
	logic        text_colour_we;
	logic [7:0]  text_colour;
	logic        done;
	logic [10:0] cursor_pos;
	logic        ok;
	logic [7:0]  cell_char;
	logic [7:0]  cell_attr;

	logic [15:0] screen [CELLS];
	int unsigned cur_cell;
	logic [7:0]  colour;
	result_t     pending [$];
	int unsigned errors;
	int unsigned idle_pct;
	int unsigned idle_cycles;

	always #1 clk = ~clk;

	text_console_writer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.char_code      (char_code),
		.position       (position),
		.line_count     (line_count),
		.text_colour_we (text_colour_we),
		.text_colour    (text_colour),
		.done           (done),
		.cursor_pos     (cursor_pos),
		.ok             (ok),
		.cell_char      (cell_char),
		.cell_attr      (cell_attr)
	);

	function automatic void shift_rows_up(int unsigned rows);
		int unsigned shift;
		if (rows > ROWS)
			rows = ROWS;
		shift = rows * COLUMNS;
		if (shift == 0)
			return;
		for (int unsigned i = 0; i + shift < CELLS; i++)
			screen[i] = screen[i + shift];
		for (int unsigned i = CELLS - shift; i < CELLS; i++)
			screen[i] = {colour, BLANK_CHAR};
		cur_cell = (cur_cell > shift) ? cur_cell - shift : 0;
	endfunction

	function automatic result_t console_step(cmd_t c);
		result_t     r;
		int unsigned next_row;
		r = '0;
		r.ok = 1'b1;
		case (c.mode)
			MODE_PUT: begin
				if (c.ch == NEWLINE) begin
					next_row = (cur_cell / COLUMNS + 1) * COLUMNS;
					cur_cell = (next_row > CELLS) ? CELLS : next_row;
				end else if (c.ch >= PRINT_LO && c.ch <= PRINT_HI) begin
					if (cur_cell >= CELLS)
						shift_rows_up(AUTO_SCROLL_ROWS);
					if (cur_cell < CELLS) begin
						screen[cur_cell] = {colour, c.ch};
						cur_cell++;
					end
				end
			end
			MODE_BKSP: begin
				if (cur_cell > 0) begin
					cur_cell--;
					screen[cur_cell] = {RESET_ATTR, BLANK_CHAR};
				end
			end
			MODE_SETCUR: begin
				if (c.pos < CELLS)
					cur_cell = c.pos;
				else
					r.ok = 1'b0;
			end
			MODE_CLEAR: begin
				foreach (screen[i])
					screen[i] = {colour, BLANK_CHAR};
			end
			MODE_SCROLL: begin
				if (c.lines > ROWS)
					r.ok = 1'b0;
				else
					shift_rows_up(c.lines);
			end
			MODE_READ: begin
				if (c.pos < CELLS)
					{r.attr, r.ch} = screen[c.pos];
				else
					r.ok = 1'b0;
			end
			default: begin
				r.ok = 1'b0;
			end
		endcase
		r.cursor = 11'(cur_cell);
		return r;
	endfunction

	// text output is the most common command, with cursor moves toward the bottom row so the
	// auto-scroll path is reached; full-screen walks are kept rare
	function automatic cmd_t rand_cmd();
		cmd_t        c;
		int unsigned pick;
		c.ch    = 8'($urandom);
		c.pos   = 11'($urandom);
		c.lines = 5'($urandom);
		pick = $urandom_range(99);
		if (pick < 45) begin
			c.mode = MODE_PUT;
			pick = $urandom_range(99);
			if (pick < 70)
				c.ch = 8'($urandom_range(PRINT_HI, PRINT_LO));
			else if (pick < 80)
				c.ch = NEWLINE;
		end else if (pick < 57) begin
			c.mode = MODE_BKSP;
		end else if (pick < 69) begin
			c.mode = MODE_SETCUR;
			pick = $urandom_range(99);
			if (pick < 50)
				c.pos = 11'($urandom_range(CELLS - 1));
			else if (pick < 80)
				c.pos = 11'($urandom_range(CELLS - 1, CELLS - COLUMNS));
		end else if (pick < 91) begin
			c.mode = MODE_READ;
			if ($urandom_range(9) != 0)
				c.pos = 11'($urandom_range(CELLS - 1));
		end else if (pick < 94) begin
			c.mode = MODE_SCROLL;
			if ($urandom_range(3) != 0)
				c.lines = 5'($urandom_range(ROWS));
		end else if (pick < 96) begin
			c.mode = MODE_CLEAR;
		end else begin
			c.mode = $urandom_range(1) ? MODE_BAD7 : MODE_BAD6;
		end
		return c;
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_cmd(cmd_t c, logic typed, result_t typed_res);
		result_t r;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		mode       <= c.mode;
		char_code  <= c.ch;
		position   <= c.pos;
		line_count <= c.lines;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = console_step(c);
		pending.push_back(typed ? typed_res : r);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (done) begin
				if (pending.size() == 0) begin
					errors++;
					$display("%0t: unexpected result cursor=%0d ok=%0b char=%h attr=%h",
						$time, cursor_pos, ok, cell_char, cell_attr);
				end else begin
					exp_res = pending.pop_front();
					if ({cursor_pos, ok, cell_char, cell_attr} !== exp_res) begin
						errors++;
						$display("%0t: mismatch expected cursor=%0d ok=%0b char=%h attr=%h,",
							$time, exp_res.cursor, exp_res.ok, exp_res.ch, exp_res.attr,
							" got cursor=%0d ok=%0b char=%h attr=%h",
							cursor_pos, ok, cell_char, cell_attr);
					end
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_text_console_writer: done, errors");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] next_colour;
		arst_n         = 1'b0;
		start          = 1'b0;
		mode           = MODE_PUT;
		char_code      = 8'h00;
		position       = 11'd0;
		line_count     = 5'd0;
		text_colour_we = 1'b0;
		text_colour    = 8'h00;
		errors         = 0;
		idle_pct       = 0;
		idle_cycles    = 0;
		foreach (screen[i])
			screen[i] = {RESET_ATTR, BLANK_CHAR};
		cur_cell = 0;
		colour   = RESET_ATTR;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i])
			send_cmd(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].res);

		foreach (PHASE_IDLE[p]) begin
			start <= 1'b0;
			while (pending.size() != 0 || busy)
				@(posedge clk);
			repeat (4) @(posedge clk);
			@(negedge clk);
			case (p)
				0: next_colour = 8'h00;
				1: next_colour = 8'hFF;
				default: next_colour = 8'($urandom);
			endcase
			text_colour_we <= 1'b1;
			text_colour    <= next_colour;
			@(negedge clk);
			text_colour_we <= 1'b0;
			colour   = next_colour;
			idle_pct = PHASE_IDLE[p];
			repeat (PHASE_ITEMS)
				send_cmd(rand_cmd(), 1'b0, NO_RES);
		end

		start <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("tb_text_console_writer: done, clean");
		else
			$display("tb_text_console_writer: done, errors");
		$finish;
	end

endmodule

// ===== text_console_writer.f =====
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_screen_ram.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer.sv
hw/rtl/tcw_checker.sv
dv/tb_text_console_writer.sv
